[design/msr_pkg.sv]
// Package for the multipart read splitter: transaction payload types, register
// indexes, error codes and the divider result type.
// No dependencies; every other design file imports it.
`default_nettype none

package msr_pkg;

    localparam int OFFSET_BITS  = 48;
    localparam int LENGTH_BITS  = 21;
    localparam int MAX_SEGMENTS = 64;

    localparam int POS_W  = 64;
    localparam int SIZE_W = 40;
    localparam int PART_W = 32;
    localparam int SKIP_W = 48;
    localparam int CFG_W  = 48;
    localparam int IDX_W  = 3;

    localparam logic [IDX_W-1:0] CFG_START_SKIP   = 3'd0;
    localparam logic [IDX_W-1:0] CFG_PART_BYTES   = 3'd1;
    localparam logic [IDX_W-1:0] CFG_HEADER_BYTES = 3'd2;
    localparam logic [IDX_W-1:0] CFG_FINAL_BYTES  = 3'd3;
    localparam logic [IDX_W-1:0] CFG_PART_COUNT   = 3'd4;

    localparam logic [1:0] ERR_OK   = 2'd0;
    localparam logic [1:0] ERR_ROOM = 2'd1;
    localparam logic [1:0] ERR_CAP  = 2'd2;

    typedef struct packed {
        logic [OFFSET_BITS-1:0] read_offset;
        logic [LENGTH_BITS-1:0] read_length;
    } req_t;

    typedef struct packed {
        logic [PART_W-1:0]      segment_part;
        logic [SIZE_W-1:0]      segment_offset;
        logic [LENGTH_BITS-1:0] segment_length;
        logic                   last_segment;
        logic [1:0]             error_code;
    } seg_t;

    typedef struct packed {
        logic [POS_W-1:0]  quot;
        logic [SIZE_W-1:0] rem;
    } div_res_t;

endpackage

`default_nettype wire

[design/msr_div.sv]
// Restoring divider, one quotient bit per cycle: 64-bit dividend by 40-bit divisor.
// Depends on msr_pkg for widths and the result type.
`default_nettype none

module msr_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [msr_pkg::POS_W-1:0]  dividend,
    input  wire logic [msr_pkg::SIZE_W-1:0] divisor,
    output logic                            done,
    output msr_pkg::div_res_t               res
);
    import msr_pkg::*;

    localparam int CNT_W = $clog2(POS_W);

    logic [POS_W-1:0]  acc_reg;
    logic [SIZE_W-1:0] rem_reg;
    logic [SIZE_W-1:0] dsor_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [SIZE_W:0]   trial;
    logic [SIZE_W-1:0] diff;
    logic              fits;

    // The partial remainder stays below the divisor, so it fits in SIZE_W bits.
    assign trial = {rem_reg, acc_reg[POS_W-1]};
    assign fits  = trial >= {1'b0, dsor_reg};
    assign diff  = trial[SIZE_W-1:0] - dsor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(POS_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg  <= dividend;
            rem_reg  <= '0;
            dsor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            acc_reg <= {acc_reg[POS_W-2:0], fits};
            rem_reg <= fits ? diff : trial[SIZE_W-1:0];
        end
    end

    assign done = done_reg;
    assign res  = '{quot: acc_reg, rem: rem_reg};

endmodule

`default_nettype wire

[design/multipart_read_splitter.sv]
// Top level of the multipart read splitter: configuration registers and the
// segment sequencer. Depends on msr_pkg and msr_div.
//
//   channel   direction  handshake            payload
//   req       in         req_valid/req_stall  msr_pkg::req_t
//   seg       out        seg_valid/seg_stall  msr_pkg::seg_t
//   cfg       in         cfg_write            cfg_index, cfg_data
//
// A request is checked in S_START, then each segment passes S_EVAL, S_EMIT
// and S_WAIT (held there on seg_stall); when the offset lies past part 0 the
// first segment waits on the one-bit-per-cycle divider. Later segments step
// part by part without it. A request of length zero gives no segment.
// Reset puts every configuration register at its reset value and idles the block.
// req_stall is high from acceptance of a nonzero-length request until its last segment has been taken.
`default_nettype none

module multipart_read_splitter #(
    parameter int MAX_SEGMENTS = msr_pkg::MAX_SEGMENTS
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_write,
    input  wire logic [msr_pkg::IDX_W-1:0] cfg_index,
    input  wire logic [msr_pkg::CFG_W-1:0] cfg_data,
    input  wire logic                      req_valid,
    output logic                           req_stall,
    input  msr_pkg::req_t                  req_data,
    output logic                           seg_valid,
    input  wire logic                      seg_stall,
    output msr_pkg::seg_t                  seg_data
);
    import msr_pkg::*;

    localparam int LEN_W = LENGTH_BITS;
    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_START = 7'b0000010,
        S_DIV   = 7'b0000100,
        S_EVAL  = 7'b0001000,
        S_EMIT  = 7'b0010000,
        S_WAIT  = 7'b0100000,
        S_STEP  = 7'b1000000
    } state_t;

    state_t             state_reg, state_next;

    logic [SKIP_W-1:0]  skip_reg;
    logic [SIZE_W-1:0]  part_bytes_reg;
    logic [SIZE_W-1:0]  header_reg;
    logic [SIZE_W-1:0]  final_reg;
    logic [PART_W-1:0]  part_count_reg;

    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               carry_reg, carry_next;
    logic [LEN_W-1:0]   left_reg, left_next;
    logic [LEN_W-1:0]   take_reg, take_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [PART_W-1:0]  part_reg, part_next;
    logic [SIZE_W-1:0]  inside_reg, inside_next;
    logic [SIZE_W-1:0]  room_reg, room_next;
    seg_t               seg_reg, seg_next;

    logic [POS_W:0]     sum_start;
    logic [POS_W:0]     sum_step;
    logic [SIZE_W-1:0]  size_sel;
    logic [LEN_W-1:0]   take;
    logic [LEN_W-1:0]   left_after;
    logic               part_is_last;
    logic               load_err;

    logic               div_start;
    logic               div_done;
    logic [POS_W-1:0]   div_dividend;
    div_res_t           div_res;

    msr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (part_bytes_reg - header_reg),
        .done     (div_done),
        .res      (div_res)
    );

    assign sum_start    = (POS_W+1)'(req_data.read_offset) + (POS_W+1)'(skip_reg);
    assign sum_step     = (POS_W+1)'(pos_reg) + (POS_W+1)'(take_reg);
    assign part_is_last = part_reg == (part_count_reg - PART_W'(1));
    assign size_sel     = part_is_last ? final_reg : part_bytes_reg;
    assign take         = (room_reg < SIZE_W'(left_reg)) ? LEN_W'(room_reg) : left_reg;
    assign left_after   = left_reg - take;
    assign div_dividend = pos_reg - POS_W'(part_bytes_reg);

    always_comb
    begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        carry_next  = carry_reg;
        left_next   = left_reg;
        take_next   = take_reg;
        count_next  = count_reg;
        part_next   = part_reg;
        inside_next = inside_reg;
        room_next   = room_reg;
        seg_next    = seg_reg;
        div_start   = 1'b0;
        load_err    = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    pos_next   = sum_start[POS_W-1:0];
                    carry_next = sum_start[POS_W];
                    left_next  = req_data.read_length;
                    count_next = '0;
                    if (req_data.read_length != '0)
                    begin
                        state_next = S_START;
                    end
                end
            end
            S_START:
            begin
                if (carry_reg || part_count_reg == '0)
                begin
                    load_err = 1'b1;
                end
                else if (pos_reg < POS_W'(part_bytes_reg))
                begin
                    part_next   = '0;
                    inside_next = pos_reg[SIZE_W-1:0];
                    state_next  = S_EVAL;
                end
                else if (header_reg >= part_bytes_reg)
                begin
                    load_err = 1'b1;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    // Part number is quotient plus one; it must stay below part_count.
                    if (div_res.quot >= (POS_W'(part_count_reg) - POS_W'(1)))
                    begin
                        load_err = 1'b1;
                    end
                    else
                    begin
                        part_next   = div_res.quot[PART_W-1:0] + PART_W'(1);
                        inside_next = div_res.rem + header_reg;
                        state_next  = S_EVAL;
                    end
                end
            end
            S_EVAL:
            begin
                if (inside_reg >= size_sel)
                begin
                    load_err = 1'b1;
                end
                else
                begin
                    room_next  = size_sel - inside_reg;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                take_next  = take;
                left_next  = left_after;
                count_next = count_reg + CNT_W'(1);
                seg_next.segment_part   = part_reg;
                seg_next.segment_offset = inside_reg;
                seg_next.segment_length = take;
                if (left_after == '0)
                begin
                    seg_next.last_segment = 1'b1;
                    seg_next.error_code   = ERR_OK;
                end
                else if (count_reg == CNT_W'(MAX_SEGMENTS - 1))
                begin
                    seg_next.last_segment = 1'b1;
                    seg_next.error_code   = ERR_CAP;
                end
                else
                begin
                    seg_next.last_segment = 1'b0;
                    seg_next.error_code   = ERR_OK;
                end
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (!seg_stall)
                begin
                    state_next = seg_reg.last_segment ? S_IDLE : S_STEP;
                end
            end
            S_STEP:
            begin
                // A segment that continues always ended its part, so the next one
                // starts at the data of the following part. Past the last part,
                // or into part 1 with a header that fills the part, or on position overflow, is an error.
                if (sum_step[POS_W] || part_is_last ||
                    (part_reg == '0 && header_reg >= part_bytes_reg))
                begin
                    load_err = 1'b1;
                end
                else
                begin
                    pos_next    = sum_step[POS_W-1:0];
                    part_next   = part_reg + PART_W'(1);
                    inside_next = header_reg;
                    state_next  = S_EVAL;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (load_err)
        begin
            seg_next.segment_part   = '0;
            seg_next.segment_offset = '0;
            seg_next.segment_length = '0;
            seg_next.last_segment   = 1'b1;
            seg_next.error_code     = ERR_ROOM;
            state_next              = S_WAIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            skip_reg       <= '0;
            part_bytes_reg <= SIZE_W'(1);
            header_reg     <= '0;
            final_reg      <= '0;
            part_count_reg <= PART_W'(1);
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_START_SKIP:   skip_reg       <= cfg_data[SKIP_W-1:0];
                    CFG_PART_BYTES:   part_bytes_reg <= cfg_data[SIZE_W-1:0];
                    CFG_HEADER_BYTES: header_reg     <= cfg_data[SIZE_W-1:0];
                    CFG_FINAL_BYTES:  final_reg      <= cfg_data[SIZE_W-1:0];
                    CFG_PART_COUNT:   part_count_reg <= cfg_data[PART_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        carry_reg  <= carry_next;
        left_reg   <= left_next;
        take_reg   <= take_next;
        count_reg  <= count_next;
        part_reg   <= part_next;
        inside_reg <= inside_next;
        room_reg   <= room_next;
        seg_reg    <= seg_next;
    end

    assign req_stall = state_reg != S_IDLE;
    assign seg_valid = state_reg == S_WAIT;
    assign seg_data  = seg_reg;

endmodule

`default_nettype wire

[test/tb_multipart_read_splitter.sv]
`timescale 1ns / 100ps
// Self-checking testbench for multipart_read_splitter: directed and random read requests
// checked segment by segment against a predictor that runs in the testbench.
// Depends on msr_pkg and the design files of the block.

module tb_multipart_read_splitter;
    import msr_pkg::*;

    localparam int          DRAIN_CYCLES = 100;
    localparam int          SETTLE_LIMIT = 100000;
    localparam logic [63:0] LEN_MAX      = 64'd1048576;
    localparam logic [63:0] MASK48       = 64'hFFFF_FFFF_FFFF;
    localparam logic [63:0] MASK40       = 64'hFF_FFFF_FFFF;
    localparam logic [63:0] MASK32       = 64'hFFFF_FFFF;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_write = 1'b0;
    logic [IDX_W-1:0] cfg_index = CFG_START_SKIP;
    logic [CFG_W-1:0] cfg_data  = '0;
    logic             req_valid = 1'b0;
    logic             req_stall;
    req_t             req_data  = '0;
    logic             seg_valid;
    logic             seg_stall = 1'b0;
    seg_t             seg_data;

    // Shadow copy of the configuration registers, starting at their reset values.
    logic [63:0] skip_bytes = 64'd0;
    logic [63:0] part_span  = 64'd1;
    logic [63:0] hdr_size   = 64'd0;
    logic [63:0] tail_span  = 64'd0;
    logic [63:0] part_total = 64'd1;

    seg_t expected_segs[$];
    int   error_count   = 0;
    int   req_count     = 0;
    int   seg_count     = 0;
    int   setting_count = 0;
    bit   req_gaps      = 1'b0;
    bit   seg_gaps      = 1'b0;

    multipart_read_splitter uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .seg_valid (seg_valid),
        .seg_stall (seg_stall),
        .seg_data  (seg_data)
    );

    always #6 clk = ~clk;

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        error_count++;
        $display("%0t mismatch: %s got 0x%0h want 0x%0h", $time, what, got, want);
    endtask

    function automatic void queue_segment(logic [63:0] part, logic [63:0] off,
                                          logic [63:0] len, logic last, logic [1:0] err);
        seg_t s;
        s.segment_part   = part[PART_W-1:0];
        s.segment_offset = off[SIZE_W-1:0];
        s.segment_length = len[LENGTH_BITS-1:0];
        s.last_segment   = last;
        s.error_code     = err;
        expected_segs.insert(expected_segs.size(), s);
    endfunction

    // Walks the request part by part and queues every segment it should produce.
    function automatic void predict_segments(req_t rq);
        logic [64:0] pos;
        logic [63:0] left, part, in_off, size, take, rest, data;
        int          count;
        pos   = {17'b0, rq.read_offset};
        left  = {43'b0, rq.read_length};
        count = 0;
        if (left == 64'd0)
            return;
        pos = pos + {1'b0, skip_bytes};
        if (pos[64] || part_total == 64'd0)
        begin
            queue_segment(64'd0, 64'd0, 64'd0, 1'b1, ERR_ROOM);
            return;
        end
        while (left != 64'd0)
        begin
            if (pos[63:0] < part_span)
            begin
                part   = 64'd0;
                in_off = pos[63:0];
            end
            else
            begin
                if (hdr_size >= part_span)
                begin
                    queue_segment(64'd0, 64'd0, 64'd0, 1'b1, ERR_ROOM);
                    return;
                end
                rest   = pos[63:0] - part_span;
                data   = part_span - hdr_size;
                part   = rest / data + 64'd1;
                in_off = rest % data + hdr_size;
            end
            if (part >= part_total)
            begin
                queue_segment(64'd0, 64'd0, 64'd0, 1'b1, ERR_ROOM);
                return;
            end
            size = (part == part_total - 64'd1) ? tail_span : part_span;
            if (in_off >= size)
            begin
                queue_segment(64'd0, 64'd0, 64'd0, 1'b1, ERR_ROOM);
                return;
            end
            take = size - in_off;
            if (take > left)
                take = left;
            left = left - take;
            if (left == 64'd0)
            begin
                queue_segment(part, in_off, take, 1'b1, ERR_OK);
                return;
            end
            if (count + 1 >= MAX_SEGMENTS)
            begin
                queue_segment(part, in_off, take, 1'b1, ERR_CAP);
                return;
            end
            queue_segment(part, in_off, take, 1'b0, ERR_OK);
            count++;
            pos = {1'b0, pos[63:0]} + {1'b0, take};
            if (pos[64])
            begin
                queue_segment(64'd0, 64'd0, 64'd0, 1'b1, ERR_ROOM);
                return;
            end
        end
    endfunction

    // Stall is sampled at the falling edge, where it has settled for the next rising edge.
    task automatic send_request(logic [63:0] offset, logic [63:0] length);
        req_t rq;
        bit   taken;
        rq.read_offset = offset[OFFSET_BITS-1:0];
        rq.read_length = length[LENGTH_BITS-1:0];
        if (req_gaps && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= rq;
        do
        begin
            @(negedge clk);
            taken = !req_stall;
            @(posedge clk);
        end while (!taken);
        predict_segments(rq);
        req_count++;
    endtask

    // Waits until every expected segment is in and the block has gone quiet.
    task automatic settle();
        req_valid <= 1'b0;
        @(negedge clk);
        for (int w = 0; w < SETTLE_LIMIT && (expected_segs.size() != 0 || req_stall); w++)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_segs.size() != 0)
        begin
            report_mismatch("segments never delivered", expected_segs.size(), 64'd0);
            expected_segs.delete();
        end
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [63:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_W-1:0];
        @(posedge clk);
    endtask

    task automatic configure(logic [63:0] skip, logic [63:0] part, logic [63:0] hdr,
                             logic [63:0] fin, logic [63:0] cnt);
        write_reg(CFG_START_SKIP, skip);
        write_reg(CFG_PART_BYTES, part);
        write_reg(CFG_HEADER_BYTES, hdr);
        write_reg(CFG_FINAL_BYTES, fin);
        write_reg(CFG_PART_COUNT, cnt);
        cfg_write  <= 1'b0;
        skip_bytes = skip & MASK48;
        part_span  = part & MASK40;
        hdr_size   = hdr & MASK40;
        tail_span  = fin & MASK40;
        part_total = cnt & MASK32;
        setting_count++;
    endtask

    always @(negedge clk)
    begin : seg_check
        seg_t want;
        if (rst_n && seg_valid && !seg_stall)
        begin
            if (expected_segs.size() == 0)
                report_mismatch("segment with nothing expected", seg_data.segment_part, 64'd0);
            else
            begin
                want = expected_segs.pop_front();
                if (seg_data.segment_part !== want.segment_part)
                    report_mismatch("segment_part", seg_data.segment_part, want.segment_part);
                if (seg_data.segment_offset !== want.segment_offset)
                    report_mismatch("segment_offset", seg_data.segment_offset,
                                    want.segment_offset);
                if (seg_data.segment_length !== want.segment_length)
                    report_mismatch("segment_length", seg_data.segment_length,
                                    want.segment_length);
                if (seg_data.last_segment !== want.last_segment)
                    report_mismatch("last_segment", seg_data.last_segment, want.last_segment);
                if (seg_data.error_code !== want.error_code)
                    report_mismatch("error_code", seg_data.error_code, want.error_code);
                seg_count++;
            end
        end
    end

    initial
    begin : seg_stall_gen
        forever
        begin
            @(posedge clk);
            if (seg_gaps && $urandom_range(0, 4) == 0)
            begin
                seg_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            seg_stall <= 1'b0;
        end
    end

    // With reset values the single part has size zero, so any real read has no room.
    task automatic test_reset_defaults();
        send_request(64'd0, 64'd0);
        send_request(64'd0, 64'd1);
        send_request(MASK48, 64'd7);
    endtask

    task automatic test_basic_split();
        settle();
        configure(64'd100, 64'd4096, 64'd64, 64'd1000, 64'd10);
        send_request(64'd0, 64'd16);
        send_request(64'd3990, 64'd200);
        // Starts in the last part and runs past the final part into a part that is absent.
        send_request(64'd36252, 64'd2000);
        // Lands beyond the end of the short final part.
        send_request(64'd37202, 64'd10);
        send_request(64'd0, LEN_MAX);
        send_request(64'd500, 64'd0);
        send_request(MASK48, 64'd1);
    endtask

    task automatic test_bad_config();
        settle();
        configure(64'd0, 64'd4096, 64'd64, 64'd4096, 64'd0);
        send_request(64'd10, 64'd5);
        settle();
        // Header as large as the part leaves no data room past part 0.
        configure(64'd0, 64'd4096, 64'd4096, 64'd4096, 64'd10);
        send_request(64'd5000, 64'd10);
        send_request(64'd10, 64'd5000);
    endtask

    task automatic test_segment_cap();
        settle();
        configure(64'd0, 64'd1, 64'd0, 64'd1, MASK32);
        send_request(64'd0, 64'd64);
        send_request(64'd3, 64'd65);
        send_request(rand64() & 64'hFFFF, LEN_MAX);
    endtask

    task automatic test_extremes();
        settle();
        configure(MASK48, MASK40, MASK40 - 64'd1, MASK40, MASK32);
        send_request(MASK48, LEN_MAX);
        send_request(64'd0, 64'd1);
        settle();
        configure(64'd0, 64'd1, 64'd0, MASK40, 64'd1);
        send_request(64'd0, 64'd1000);
        send_request(64'd1, 64'd5);
    endtask

    task automatic test_random_phase(int items);
        logic [63:0] skip, part, hdr, fin, cnt, data, tpos, off, len, lim;
        int          kmax, k;
        case ($urandom_range(0, 3))
            0: part = $urandom_range(1, 64);
            1: part = $urandom_range(256, 65536);
            2: part = $urandom_range(65536, 2000000);
            default: part = (rand64() & MASK40) | 64'd1;
        endcase
        case ($urandom_range(0, 9))
            0: hdr = part + $urandom_range(0, 3);
            1, 2, 3: hdr = rand64() % part;
            default: hdr = rand64() % (part / 4 + 64'd1);
        endcase
        case ($urandom_range(0, 5))
            0, 1, 2: cnt = $urandom_range(2, 16);
            3: cnt = $urandom_range(1, 3);
            4: cnt = MASK32;
            default: cnt = $urandom;
        endcase
        case ($urandom_range(0, 5))
            0, 1: fin = part;
            2, 3: fin = rand64() % (part + 64'd1);
            4: fin = 64'd0;
            default: fin = rand64() & MASK40;
        endcase
        case ($urandom_range(0, 3))
            0: skip = 64'd0;
            1, 2: skip = $urandom_range(0, 4096);
            default: skip = rand64() & MASK48;
        endcase
        settle();
        configure(skip, part, hdr, fin, cnt);
        data = (hdr < part) ? part - hdr : 64'd1;
        kmax = (cnt > 64'd16) ? 17 : int'(cnt);
        lim  = (part * 4 > LEN_MAX) ? LEN_MAX : part * 4;
        repeat (items)
        begin
            if ($urandom_range(0, 4) == 0)
                off = rand64() & MASK48;
            else
            begin
                // Aim at a byte inside some part, usually one that exists.
                k = $urandom_range(0, kmax);
                if (k == 0)
                    tpos = rand64() % part;
                else
                    tpos = part + (k - 1) * data + rand64() % data;
                off = (tpos >= skip) ? tpos - skip : rand64();
                off = off & MASK48;
            end
            case ($urandom_range(0, 9))
                0, 1: len = $urandom_range(1, 16);
                2, 3, 4, 5: len = $urandom_range(1, lim[31:0]);
                6, 7: len = $urandom_range(0, LEN_MAX[31:0]);
                8: len = LEN_MAX;
                default: len = $urandom_range(0, 3);
            endcase
            send_request(off, len);
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        req_gaps = 1'b1;
        seg_gaps = 1'b1;
        test_reset_defaults();
        test_basic_split();
        test_bad_config();
        test_segment_cap();
        test_extremes();
        for (int p = 0; p < 8; p++)
        begin
            if (p >= 6)
            begin
                req_gaps = 1'b0;
                seg_gaps = 1'b0;
            end
            test_random_phase(38);
        end
        settle();
        $display("Run covered %0d read requests, %0d checked segments, %0d register settings.",
                 req_count, seg_count, setting_count);
        if (error_count == 0)
            $display("tb_multipart_read_splitter: clean");
        else
            $display("tb_multipart_read_splitter: errors");
        $finish;
    end

    initial
    begin
        #30000000;
        $display("Run stopped by timeout.");
        $display("tb_multipart_read_splitter: errors");
        $finish;
    end

endmodule
